@@ hdl/crt_pkg.sv @@
// Package for the cascaded reload timers: control field positions, register
// indexes, prescale codes and the per-timer step function.
// Depends on nothing; used by cascaded_reload_timers_top and tb_top.
package crt_pkg;

    localparam int TIMER_COUNT = 4;

    localparam int CTL_WIDTH = 8;
    localparam int RELOAD_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int RESIDUAL_WIDTH = 18;
    localparam int ELAPSED_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int PERIOD_WIDTH = 11;

    localparam int CTL_CASCADE_BIT = 2;
    localparam int CTL_IRQ_BIT = 6;
    localparam int CTL_ENABLE_BIT = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONTROL_BASE = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELOAD_BASE = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIMIT = 4'd8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [RESIDUAL_WIDTH-1:0] RESIDUAL_SPAN = 18'h10000;
    localparam logic signed [RESIDUAL_WIDTH:0] RESIDUAL_MIN = -19'sd131072;

    typedef enum logic [1:0] {
        PRE_1    = 2'd0,
        PRE_64   = 2'd1,
        PRE_256  = 2'd2,
        PRE_1024 = 2'd3
    } t_prescale;

    typedef logic [CTL_WIDTH-1:0] t_control;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic signed [RESIDUAL_WIDTH-1:0] t_residual;

    typedef struct packed {
        t_count    counter;
        t_residual residual;
        logic      ovf;
    } t_timer_next;

    function automatic logic [PERIOD_WIDTH-1:0] prescale_period(input t_prescale sel);
        logic [PERIOD_WIDTH-1:0] p;
        case (sel)
            PRE_1:    p = 11'd1;
            PRE_64:   p = 11'd64;
            PRE_256:  p = 11'd256;
            PRE_1024: p = 11'd1024;
            default:  p = 11'd1;
        endcase
        return p;
    endfunction

    function automatic t_timer_next timer_step(
        input t_control                 ctl,
        input t_count                   reload,
        input t_count                   counter,
        input t_residual                residual,
        input logic [ELAPSED_WIDTH-1:0] elapsed,
        input logic                     below_ovf,
        input logic                     can_cascade
    );
        logic [COUNT_WIDTH:0]           sum;
        t_count                         c;
        logic signed [RESIDUAL_WIDTH:0] r;
        t_timer_next                    res;
        res.counter = counter;
        res.residual = residual;
        res.ovf = 1'b0;
        sum = '0;
        c = counter;
        r = '0;
        if (ctl[CTL_ENABLE_BIT]) begin
            if (can_cascade && ctl[CTL_CASCADE_BIT]) begin
                if (below_ovf) begin
                    if (counter == COUNT_MAX) begin
                        res.counter = reload;
                        res.ovf = 1'b1;
                    end else begin
                        res.counter = counter + 16'd1;
                    end
                end
            end else if (t_prescale'(ctl[1:0]) == PRE_1) begin
                sum = {1'b0, counter} + {1'b0, elapsed};
                c = sum[COUNT_WIDTH-1:0];
                if (sum[COUNT_WIDTH]) begin
                    c = sum[COUNT_WIDTH-1:0] + reload;
                    res.ovf = 1'b1;
                end
                if (c < reload) begin
                    c = reload;
                end
                res.counter = c;
                res.residual = RESIDUAL_SPAN - {2'b00, c};
            end else begin
                r = {residual[RESIDUAL_WIDTH-1], residual} - {3'b000, elapsed};
                if (r <= 0) begin
                    r = r + {8'b0, prescale_period(t_prescale'(ctl[1:0]))};
                    if (counter == COUNT_MAX) begin
                        res.counter = reload;
                        res.ovf = 1'b1;
                    end else begin
                        res.counter = counter + 16'd1;
                    end
                end
                if (r < RESIDUAL_MIN) begin
                    r = RESIDUAL_MIN;
                end
                res.residual = r[RESIDUAL_WIDTH-1:0];
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/cascaded_reload_timers_top.sv @@
// Top level of the four cascadable 16-bit reload timers.
// Depends on crt_pkg for field positions, prescale codes and the step function.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready  | i_elapsed_cycles, i_stop_state
//  out     | output    | o_out_valid / i_out_ready| o_count_*, o_irq_request, o_sound_overflow
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; each result is registered.
// The path from the input register through the four chained timer steps to the result
// register sets the clock limit.
// Reset is synchronous and clears control, reload, counters, residuals and both valid flags.
// A stalled output holds its result while one more item waits in the input register.
module cascaded_reload_timers_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [crt_pkg::ELAPSED_WIDTH-1:0]    i_elapsed_cycles,
    input  logic                                 i_stop_state,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [crt_pkg::COUNT_WIDTH-1:0]      o_count_zero,
    output logic [crt_pkg::COUNT_WIDTH-1:0]      o_count_one,
    output logic [crt_pkg::COUNT_WIDTH-1:0]      o_count_two,
    output logic [crt_pkg::COUNT_WIDTH-1:0]      o_count_three,
    output logic [crt_pkg::TIMER_COUNT-1:0]      o_irq_request,
    output logic [1:0]                           o_sound_overflow,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [crt_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [crt_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    import crt_pkg::*;

    t_control                   r_control [TIMER_COUNT];
    t_count                     r_reload [TIMER_COUNT];
    t_count                     r_counter [TIMER_COUNT];
    t_residual                  r_residual [TIMER_COUNT];

    logic                       r_in_valid;
    logic [ELAPSED_WIDTH-1:0]   r_elapsed;
    logic                       r_stop;

    logic                       r_out_valid;
    t_count                     r_out_count [TIMER_COUNT];
    logic [TIMER_COUNT-1:0]     r_out_irq;
    logic [1:0]                 r_out_sound;

    t_timer_next                step [TIMER_COUNT];
    t_count                     n_counter [TIMER_COUNT];
    t_residual                  n_residual [TIMER_COUNT];
    logic [TIMER_COUNT-1:0]     n_irq;
    logic [1:0]                 n_sound;
    logic                       advance;

    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
            step[t] = timer_step(r_control[t], r_reload[t], r_counter[t], r_residual[t],
                                 r_elapsed, (t > 0) ? step[(t > 0) ? t - 1 : 0].ovf : 1'b0,
                                 (t > 0));
        end
        for (int t = 0; t < TIMER_COUNT; t++) begin
            if (r_stop) begin
                n_counter[t] = r_counter[t];
                n_residual[t] = r_residual[t];
                n_irq[t] = 1'b0;
            end else begin
                n_counter[t] = step[t].counter;
                n_residual[t] = step[t].residual;
                n_irq[t] = step[t].ovf && r_control[t][CTL_IRQ_BIT];
            end
        end
        n_sound = r_stop ? 2'b00 : {step[1].ovf, step[0].ovf};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_control[t] <= '0;
                r_reload[t] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index < CFG_RELOAD_BASE) begin
                r_control[i_cfg_index[1:0]] <= i_cfg_data[CTL_WIDTH-1:0];
            end else if (i_cfg_index < CFG_LIMIT) begin
                r_reload[i_cfg_index[1:0]] <= i_cfg_data[RELOAD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_elapsed <= i_elapsed_cycles;
            r_stop <= i_stop_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_counter[t] <= '0;
                r_residual[t] <= '0;
            end
        end else if (advance) begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_counter[t] <= n_counter[t];
                r_residual[t] <= n_residual[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_out_count[t] <= n_counter[t];
            end
            r_out_irq <= n_irq;
            r_out_sound <= n_sound;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count_zero = r_out_count[0];
    assign o_count_one = r_out_count[1];
    assign o_count_two = r_out_count[2];
    assign o_count_three = r_out_count[3];
    assign o_irq_request = r_out_irq;
    assign o_sound_overflow = r_out_sound;

endmodule

@@ hdl/crt_checker.sv @@
// Port-level checker for cascaded_reload_timers_top and the bind that attaches it.
// Depends only on the top level's ports.
module crt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_count_zero,
    input logic [15:0] o_count_three,
    input logic [3:0]  o_irq_request,
    input logic [1:0]  o_sound_overflow
);

    // A result waiting on the output must hold until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_count_zero)
            && $stable(o_count_three) && $stable(o_irq_request)))
        else $error("result changed while stalled");

    // An interrupt from timer zero or one always comes with its overflow flag.
    a_irq_sound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((!o_irq_request[0] || o_sound_overflow[0])
            && (!o_irq_request[1] || o_sound_overflow[1])))
        else $error("irq without matching overflow");

    // The input side only stalls behind a full output register.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // No result is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind cascaded_reload_timers_top crt_checker u_crt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_count_zero     (o_count_zero),
    .o_count_three    (o_count_three),
    .o_irq_request    (o_irq_request),
    .o_sound_overflow (o_sound_overflow)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cascaded_reload_timers_top: a timer scoreboard predicts
// every result transaction while directed and random stimulus runs under varied configs.
// Depends on crt_pkg and cascaded_reload_timers_top.
module tb_top;
    import crt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_REPORTS = 10;
    localparam int RESIDUAL_FLOOR = -131072;
    localparam int RESULT_LATENCY = 2;

    typedef struct packed {
        logic [TIMER_COUNT-1:0][COUNT_WIDTH-1:0] counts;
        logic [TIMER_COUNT-1:0]                  irq;
        logic [1:0]                              snd;
    } t_timer_result;

    class timer_scoreboard;
        t_control      ctl[TIMER_COUNT];
        t_count        reload[TIMER_COUNT];
        t_count        count[TIMER_COUNT];
        int            residual[TIMER_COUNT];
        t_timer_result expected_q[$];
        int            failures;
        int            checked;
        int            overflows;
        int            stopped;

        function new();
            for (int t = 0; t < TIMER_COUNT; t++) begin
                ctl[t] = '0;
                reload[t] = '0;
                count[t] = '0;
                residual[t] = 0;
            end
            failures = 0;
            checked = 0;
            overflows = 0;
            stopped = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] data);
            if (idx < CFG_RELOAD_BASE) begin
                ctl[idx - CFG_CONTROL_BASE] = data[CTL_WIDTH-1:0];
            end else if (idx < CFG_LIMIT) begin
                reload[idx - CFG_RELOAD_BASE] = data;
            end
        endfunction

        function void note_item(logic [ELAPSED_WIDTH-1:0] elapsed, logic stop);
            t_timer_result want;
            logic          below;
            logic          ovf;
            logic          step;
            int            sum;
            int            acc;
            int            period;
            t_count        nxt;
            want = '0;
            below = 1'b0;
            if (stop) begin
                stopped++;
            end else begin
                for (int t = 0; t < TIMER_COUNT; t++) begin
                    ovf = 1'b0;
                    step = 1'b0;
                    if (ctl[t][CTL_ENABLE_BIT]) begin
                        if (t > 0 && ctl[t][CTL_CASCADE_BIT]) begin
                            step = below;
                        end else if (t_prescale'(ctl[t][1:0]) == PRE_1) begin
                            sum = int'(count[t]) + int'(elapsed);
                            if (sum > int'(COUNT_MAX)) begin
                                sum = sum + int'(reload[t]);
                                ovf = 1'b1;
                            end
                            nxt = sum[COUNT_WIDTH-1:0];
                            if (nxt < reload[t]) begin
                                nxt = reload[t];
                            end
                            count[t] = nxt;
                            residual[t] = 65536 - int'(nxt);
                        end else begin
                            case (t_prescale'(ctl[t][1:0]))
                                PRE_64:  period = 64;
                                PRE_256: period = 256;
                                default: period = 1024;
                            endcase
                            acc = residual[t] - int'(elapsed);
                            if (acc <= 0) begin
                                acc = acc + period;
                                step = 1'b1;
                            end
                            if (acc < RESIDUAL_FLOOR) begin
                                acc = RESIDUAL_FLOOR;
                            end
                            residual[t] = acc;
                        end
                        if (step) begin
                            if (count[t] == COUNT_MAX) begin
                                count[t] = reload[t];
                                ovf = 1'b1;
                            end else begin
                                count[t] = count[t] + 16'd1;
                            end
                        end
                    end
                    if (ovf) begin
                        overflows++;
                        if (ctl[t][CTL_IRQ_BIT]) begin
                            want.irq[t] = 1'b1;
                        end
                        if (t < 2) begin
                            want.snd[t] = 1'b1;
                        end
                    end
                    below = ovf;
                end
            end
            for (int t = 0; t < TIMER_COUNT; t++) begin
                want.counts[t] = count[t];
            end
            expected_q.push_back(want);
        endfunction

        function void check_result(t_timer_result got);
            t_timer_result want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("Unexpected result transaction: counts %h irq %b sound %b",
                             got.counts, got.irq, got.snd);
                end
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.counts !== want.counts || got.irq !== want.irq || got.snd !== want.snd) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("Mismatch on result %0d:", checked);
                    $display("  expected counts %h irq %b sound %b",
                             want.counts, want.irq, want.snd);
                    $display("  actual   counts %h irq %b sound %b",
                             got.counts, got.irq, got.snd);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close();
            if (expected_q.size() != 0) begin
                failures += expected_q.size();
                $display("%0d result transactions never arrived.", expected_q.size());
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [ELAPSED_WIDTH-1:0]   i_elapsed_cycles;
    logic                       i_stop_state;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [COUNT_WIDTH-1:0]     o_count_zero;
    logic [COUNT_WIDTH-1:0]     o_count_one;
    logic [COUNT_WIDTH-1:0]     o_count_two;
    logic [COUNT_WIDTH-1:0]     o_count_three;
    logic [TIMER_COUNT-1:0]     o_irq_request;
    logic [1:0]                 o_sound_overflow;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    timer_scoreboard sb = new();
    int send_idle_pct = 21;
    int recv_idle_pct = 50;
    int quiet_cycles = 0;
    int setting_count = 0;
    int item_count = 0;

    cascaded_reload_timers_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_elapsed_cycles (i_elapsed_cycles),
        .i_stop_state     (i_stop_state),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_count_zero     (o_count_zero),
        .o_count_one      (o_count_one),
        .o_count_two      (o_count_two),
        .o_count_three    (o_count_three),
        .o_irq_request    (o_irq_request),
        .o_sound_overflow (o_sound_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_count_three, o_count_two, o_count_one, o_count_zero,
                             o_irq_request, o_sound_overflow});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic program_timers(input logic [15:0] c0, input logic [15:0] c1,
                                  input logic [15:0] c2, input logic [15:0] c3,
                                  input logic [15:0] r0, input logic [15:0] r1,
                                  input logic [15:0] r2, input logic [15:0] r3);
        logic [CFG_INDEX_WIDTH-1:0] idx_list[9];
        logic [CFG_DATA_WIDTH-1:0]  data_list[9];
        data_list[0] = c0;
        data_list[1] = c1;
        data_list[2] = c2;
        data_list[3] = c3;
        data_list[4] = r0;
        data_list[5] = r1;
        data_list[6] = r2;
        data_list[7] = r3;
        for (int t = 0; t < TIMER_COUNT; t++) begin
            idx_list[t] = CFG_CONTROL_BASE + CFG_INDEX_WIDTH'(t);
            idx_list[t + 4] = CFG_RELOAD_BASE + CFG_INDEX_WIDTH'(t);
        end
        // An index past the register file must be ignored.
        idx_list[8] = CFG_LIMIT + CFG_INDEX_WIDTH'($urandom_range(7));
        data_list[8] = CFG_DATA_WIDTH'($urandom_range(16'hFFFF));
        for (int i = 0; i < 9; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[i];
            i_cfg_data <= data_list[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx_list[i], data_list[i]);
        end
        i_cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic send_item(input logic [ELAPSED_WIDTH-1:0] elapsed, input logic stop);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elapsed_cycles <= elapsed;
        i_stop_state <= stop;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(elapsed, stop);
        item_count++;
    endtask

    task automatic settle_phase();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0]              c[TIMER_COUNT];
        logic [15:0]              r[TIMER_COUNT];
        logic [ELAPSED_WIDTH-1:0] e;
        int                       sel;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_elapsed_cycles <= '0;
        i_stop_state <= 1'b0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Prescale 1 everywhere with reload at the top clamps every counter to 0xFFFF.
        program_timers(16'h00C0, 16'h00C0, 16'h00C0, 16'h00C0,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'h0001, 1'b0);
        settle_phase();

        // Timer 0 overflow ripples through all three cascaded timers; the
        // cascade bit on timer 0 must be ignored.
        program_timers(16'h00C4, 16'h00C4, 16'h00C4, 16'h0084,
                       16'hFFF0, 16'h0010, 16'h0000, 16'h8000);
        send_item(16'h0010, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        settle_phase();

        // Divided prescales, residual saturation, and a disabled timer.
        program_timers(16'h00C1, 16'h0042 | 16'h0080, 16'h00C3, 16'h0003,
                       16'hFF00, 16'hFFFE, 16'h0000, 16'hFFFF);
        repeat (4) send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'd63, 1'b0);
        send_item(16'd64, 1'b0);
        send_item(16'd1024, 1'b0);
        send_item(16'h0155, 1'b1);
        settle_phase();

        // Every timer disabled with all other control bits set.
        program_timers(16'hFF7F, 16'h007F, 16'h7F7F, 16'h007F,
                       16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'hAAAA, 1'b0);
        send_item(16'h5555, 1'b0);
        settle_phase();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < RANDOM_PHASES / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 50;
            end else if (phase < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int t = 0; t < TIMER_COUNT; t++) begin
                c[t] = 16'($urandom_range(16'hFFFF));
                if ($urandom_range(99) < 80) begin
                    c[t][CTL_ENABLE_BIT] = 1'b1;
                end
                case ($urandom_range(9))
                    0:       r[t] = 16'h0000;
                    1:       r[t] = 16'hFFFF;
                    2, 3:    r[t] = 16'($urandom_range(16'hFFFF));
                    default: r[t] = 16'($urandom_range(16'hFFFF, 16'hFF00));
                endcase
                if (phase == 3) begin
                    c[t] = 16'hFFFF;
                    r[t] = 16'hFFFF;
                end else if (phase == 9) begin
                    c[t] = 16'h0080;
                    r[t] = 16'h0000;
                end
            end
            program_timers(c[0], c[1], c[2], c[3], r[0], r[1], r[2], r[3]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                sel = $urandom_range(99);
                if (sel < 30) begin
                    e = ELAPSED_WIDTH'($urandom_range(80));
                end else if (sel < 55) begin
                    e = ELAPSED_WIDTH'($urandom_range(1100, 60));
                end else if (sel < 75) begin
                    e = ELAPSED_WIDTH'($urandom_range(16'hFFFF));
                end else if (sel < 85) begin
                    e = ELAPSED_WIDTH'($urandom_range(16'hFFFF, 16'hF000));
                end else begin
                    e = ELAPSED_WIDTH'($urandom_range(4096));
                end
                send_item(e, $urandom_range(99) < 8);
            end
            settle_phase();
        end

        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
        sb.close();
        $display("Ran %0d timer settings and %0d transactions,", setting_count, item_count);
        $display("%0d of them with the timers stopped; %0d timer overflows predicted.",
                 sb.stopped, sb.overflows);
        $display("%0d results checked, %0d failures.", sb.checked, sb.failures);
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/crt_pkg.sv
hdl/cascaded_reload_timers_top.sv
hdl/crt_checker.sv
verif/tb_top.sv
